[src/gnoise_pkg.sv]
// Shared constants, types and tables for the gradient noise core.
package gnoise_pkg;

  localparam int FracBits    = 16;
  localparam int OutFracBits = 16;
  localparam int CoordW      = 32;
  localparam int OutW        = 18;
  localparam int ValW        = FracBits + 4;

  typedef logic [7:0] idx_t;
  typedef logic signed [ValW-1:0] val_t;

  localparam logic signed [OutW-1:0] OutMax = 18'sh1FFFF;
  localparam logic signed [OutW-1:0] OutMin = -18'sh20000;

  localparam logic [7:0] PermTab [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
    8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
    8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
    8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
    8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
    8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
    8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
    8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
    8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
    8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic idx_t perm(input idx_t i);
    perm = PermTab[i];
  endfunction

  function automatic val_t grad3(input logic [3:0] h, input val_t x, input val_t y,
                                 input val_t z);
    val_t r;
    r = '0;
    case (h)
      4'd0, 4'd12: r = x + y;
      4'd1, 4'd13: r = y - x;
      4'd2:        r = x - y;
      4'd3:        r = -x - y;
      4'd4:        r = x + z;
      4'd5:        r = z - x;
      4'd6:        r = x - z;
      4'd7:        r = -x - z;
      4'd8:        r = y + z;
      4'd9, 4'd14: r = z - y;
      4'd10:       r = y - z;
      4'd11, 4'd15: r = -y - z;
      default:     r = '0;
    endcase
    grad3 = r;
  endfunction

  function automatic val_t grad2(input logic [1:0] h, input val_t x, input val_t y);
    val_t r;
    r = '0;
    case (h)
      2'd0:    r = x + y;
      2'd1:    r = y - x;
      2'd2:    r = x - y;
      default: r = -x - y;
    endcase
    grad2 = r;
  endfunction

endpackage

[src/gnoise_fade.sv]
// Pipelined fade t^4*(6t^2 - 15t + 10) of one fraction, five register stages.
module gnoise_fade (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [gnoise_pkg::FracBits-1:0]  t_i,
  output logic [gnoise_pkg::FracBits:0]    fade_o
);
  import gnoise_pkg::*;

  localparam int TW = FracBits + 1;
  localparam int SW = FracBits + 6;
  localparam int PW = TW + SW + 1;

  typedef logic signed [TW-1:0] t_s_t;
  typedef logic signed [SW-1:0] s_t;
  typedef logic signed [PW-1:0] p_t;

  localparam s_t One = s_t'(64'sd1 <<< FracBits);

  t_s_t t1_q, t2_q, t3_q;
  s_t   a1_q, b2_q, c3_q, q2_q, q3_q, r4_q, c4_q;
  logic [FracBits:0] f5_q;
  p_t   pb, pc, pq, pr, pf;

  always_comb begin
    pb = p_t'(t1_q) * p_t'(a1_q);
    pq = p_t'(t1_q) * p_t'(t1_q);
    pc = p_t'(t2_q) * p_t'(b2_q);
    pr = p_t'(q3_q) * p_t'(t3_q);
    pf = p_t'(r4_q) * p_t'(c4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= t_s_t'({1'b0, t_i});
      a1_q <= s_t'(6) * s_t'({1'b0, t_i}) - s_t'(15) * One;
      t2_q <= t1_q;
      b2_q <= s_t'(pb >>> FracBits) + s_t'(10) * One;
      q2_q <= s_t'(pq >>> FracBits);
      t3_q <= t2_q;
      c3_q <= s_t'(pc >>> FracBits);
      q3_q <= q2_q;
      c4_q <= c3_q;
      r4_q <= s_t'(pr >>> FracBits);
      f5_q <= TW'(pf >>> FracBits);
    end
  end

  assign fade_o = f5_q;
endmodule

[src/gradient_noise_2d_3d_core.sv]
// Top level: fully pipelined 2D/3D improved gradient noise.
// Throughput: one point per cycle; the pipeline advances whenever the
// output register is empty or taken, so a stall freezes every stage.
// Reset clears only the stage valid bits; the hash table is constant logic.
module gradient_noise_2d_3d_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic signed [gnoise_pkg::CoordW-1:0]  x_coord_i,
  input  logic signed [gnoise_pkg::CoordW-1:0]  y_coord_i,
  input  logic signed [gnoise_pkg::CoordW-1:0]  z_coord_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [gnoise_pkg::OutW-1:0]    noise_value_o
);
  import gnoise_pkg::*;

  localparam int Depth = 11;
  localparam int FB = FracBits;
  localparam int MW = ValW + FB + 2;

  typedef logic signed [MW-1:0] m_t;

  logic [Depth-1:0] vld_q;
  logic adv;

  assign adv = !vld_q[Depth-1] || !out_stall_i;
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 1: split coordinates
  logic [FB-1:0] fx1_q, fy1_q, fz1_q;
  idx_t xi1_q, yi1_q, zi1_q;
  logic m1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx1_q <= x_coord_i[FB-1:0];
      fy1_q <= y_coord_i[FB-1:0];
      fz1_q <= z_coord_i[FB-1:0];
      xi1_q <= x_coord_i[FB+7:FB];
      yi1_q <= y_coord_i[FB+7:FB];
      zi1_q <= z_coord_i[FB+7:FB];
      m1_q  <= action_i;
    end
  end

  // fades: stages 2..6
  logic [FB:0] u6, v6, w6;
  gnoise_fade u_fx (.clk_i, .en_i(adv), .t_i(fx1_q), .fade_o(u6));
  gnoise_fade u_fy (.clk_i, .en_i(adv), .t_i(fy1_q), .fade_o(v6));
  gnoise_fade u_fz (.clk_i, .en_i(adv), .t_i(fz1_q), .fade_o(w6));

  // hash: stage 2 first level, stage 3 second, stage 4 third
  idx_t ha2_q [2];
  idx_t yi2_q, zi2_q;
  idx_t hb3_q [4];
  idx_t zi3_q;
  idx_t hc4_q [8];
  idx_t hb4_q [4];
  logic [FB-1:0] fxp_q [2:4];
  logic [FB-1:0] fyp_q [2:4];
  logic [FB-1:0] fzp_q [2:4];
  logic mp_q [2:4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ha2_q[0] <= perm(xi1_q);
      ha2_q[1] <= perm(xi1_q + 8'd1);
      yi2_q <= yi1_q;
      zi2_q <= zi1_q;
      for (int i = 0; i < 2; i++) begin
        hb3_q[2*i]   <= perm(ha2_q[i] + yi2_q);
        hb3_q[2*i+1] <= perm(ha2_q[i] + yi2_q + 8'd1);
      end
      zi3_q <= zi2_q;
      for (int j = 0; j < 4; j++) begin
        hc4_q[2*j]   <= perm(hb3_q[j] + zi3_q);
        hc4_q[2*j+1] <= perm(hb3_q[j] + zi3_q + 8'd1);
      end
      hb4_q <= hb3_q;
      fxp_q[2] <= fx1_q; fyp_q[2] <= fy1_q; fzp_q[2] <= fz1_q; mp_q[2] <= m1_q;
      fxp_q[3] <= fxp_q[2]; fyp_q[3] <= fyp_q[2]; fzp_q[3] <= fzp_q[2]; mp_q[3] <= mp_q[2];
      fxp_q[4] <= fxp_q[3]; fyp_q[4] <= fyp_q[3]; fzp_q[4] <= fzp_q[3]; mp_q[4] <= mp_q[3];
    end
  end

  // stage 5: corner dots; index is x + 2y + 4z
  val_t g5_q [8];
  logic m5_q;
  val_t fxs, fys, fzs, one_v;
  assign one_v = val_t'(64'sd1 <<< FB);
  assign fxs = val_t'({1'b0, fxp_q[4]});
  assign fys = val_t'({1'b0, fyp_q[4]});
  assign fzs = val_t'({1'b0, fzp_q[4]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        val_t dx, dy, dz;
        idx_t h;
        dx = (k & 1) != 0 ? fxs - one_v : fxs;
        dy = (k & 2) != 0 ? fys - one_v : fys;
        dz = (k & 4) != 0 ? fzs - one_v : fzs;
        h  = mp_q[4] ? hc4_q[((k & 1) << 2) | (k & 2) | ((k >> 2) & 1)]
                     : hb4_q[((k & 1) << 1) | ((k >> 1) & 1)];
        g5_q[k] <= mp_q[4] ? grad3(h[3:0], dx, dy, dz) : grad2(h[1:0], dx, dy);
      end
      m5_q <= mp_q[4];
    end
  end

  // stage 6: align corners with fades
  val_t g6_q [8];
  logic m6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g6_q <= g5_q;
      m6_q <= m5_q;
    end
  end

  function automatic val_t mix(input val_t a, input val_t b, input logic [FB:0] s);
    m_t p;
    p = m_t'(b - a) * m_t'({1'b0, s});
    mix = a + val_t'(p >>> FB);
  endfunction

  // stage 7: x lerp
  val_t x7_q [4];
  logic [FB:0] v7_q, w7_q, w8_q;
  logic m7_q, m8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int q = 0; q < 4; q++) x7_q[q] <= mix(g6_q[2*q], g6_q[2*q+1], u6);
      v7_q <= v6;
      w7_q <= w6;
      m7_q <= m6_q;
    end
  end

  // stage 8: y lerp
  val_t y8_q [2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y8_q[0] <= mix(x7_q[0], x7_q[1], v7_q);
      y8_q[1] <= mix(x7_q[2], x7_q[3], v7_q);
      w8_q <= w7_q;
      m8_q <= m7_q;
    end
  end

  // stage 9: z lerp
  val_t r9_q;
  always_ff @(posedge clk_i) begin
    if (adv) r9_q <= m8_q ? mix(y8_q[0], y8_q[1], w8_q) : y8_q[0];
  end

  // stage 10: rescale
  localparam int SW = ValW + 24;
  logic signed [SW-1:0] r10_q, sc;
  always_comb begin
    if (OutFracBits >= FracBits) sc = SW'(r9_q) <<< (OutFracBits - FracBits);
    else sc = SW'(r9_q) >>> (FracBits - OutFracBits);
  end
  always_ff @(posedge clk_i) begin
    if (adv) r10_q <= sc;
  end

  // stage 11: saturate into output register
  logic signed [OutW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (r10_q > SW'(OutMax)) out_q <= OutMax;
      else if (r10_q < SW'(OutMin)) out_q <= OutMin;
      else out_q <= r10_q[OutW-1:0];
    end
  end
  assign noise_value_o = out_q;
endmodule

[src/gnoise_checker.sv]
// Port-level checker for the gradient noise core, bound to the top level.
module gnoise_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic signed [gnoise_pkg::OutW-1:0] noise_value_o
);
  import gnoise_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled output transaction changed");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");
endmodule

bind gradient_noise_2d_3d_core gnoise_checker u_gnoise_checker (.*);

[sim/gradient_noise_2d_3d_core_tb.sv]
// Self-checking bench for the gradient noise core: random and directed points.
module gradient_noise_2d_3d_core_tb;
  import gnoise_pkg::*;

  localparam int NumRandom = 450;

  class noise_scoreboard;
    logic signed [OutW-1:0] pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function automatic longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint fade(longint t);
      longint one, a, b, c, t2, t3;
      one = longint'(1) <<< FracBits;
      a = 6 * t - 15 * one;
      b = fshift(t * a, FracBits) + 10 * one;
      c = fshift(t * b, FracBits);
      t2 = fshift(t * t, FracBits);
      t3 = fshift(t2 * t, FracBits);
      return fshift(t3 * c, FracBits);
    endfunction

    function automatic longint blend(longint a, longint b, longint s);
      return a + fshift((b - a) * s, FracBits);
    endfunction

    function automatic logic [7:0] hash2(logic [7:0] x, logic [7:0] y);
      logic [7:0] s;
      s = PermTab[x] + y;
      return PermTab[s];
    endfunction

    function automatic logic [7:0] hash3(logic [7:0] x, logic [7:0] y, logic [7:0] z);
      logic [7:0] s;
      s = hash2(x, y) + z;
      return PermTab[s];
    endfunction

    function automatic longint dot2(logic [7:0] h, longint dx, longint dy);
      case (h[1:0])
        2'd0: return dx + dy;
        2'd1: return dy - dx;
        2'd2: return dx - dy;
        default: return -dx - dy;
      endcase
    endfunction

    function automatic longint dot3(logic [7:0] h, longint dx, longint dy, longint dz);
      case (h[3:0])
        4'd0, 4'd12: return dx + dy;
        4'd1, 4'd13: return dy - dx;
        4'd2: return dx - dy;
        4'd3: return -dx - dy;
        4'd4: return dx + dz;
        4'd5: return dz - dx;
        4'd6: return dx - dz;
        4'd7: return -dx - dz;
        4'd8: return dy + dz;
        4'd9, 4'd14: return dz - dy;
        4'd10: return dy - dz;
        default: return -dy - dz;
      endcase
    endfunction

    function automatic logic signed [OutW-1:0] noise(logic three, logic [31:0] cx,
                                                      logic [31:0] cy, logic [31:0] cz);
      logic [7:0] xi, yi, zi, xj, yj, zj;
      longint one, fx, fy, fz, gx, gy, gz, u, v, w, r, x0, x1, x00, x10, x01, x11;
      one = longint'(1) <<< FracBits;
      xi = cx[FracBits +: 8]; yi = cy[FracBits +: 8]; zi = cz[FracBits +: 8];
      xj = xi + 8'd1; yj = yi + 8'd1; zj = zi + 8'd1;
      fx = longint'(cx[FracBits-1:0]);
      fy = longint'(cy[FracBits-1:0]);
      fz = longint'(cz[FracBits-1:0]);
      gx = fx - one; gy = fy - one; gz = fz - one;
      u = fade(fx); v = fade(fy);
      if (three) begin
        w = fade(fz);
        x00 = blend(dot3(hash3(xi, yi, zi), fx, fy, fz), dot3(hash3(xj, yi, zi), gx, fy, fz), u);
        x10 = blend(dot3(hash3(xi, yj, zi), fx, gy, fz), dot3(hash3(xj, yj, zi), gx, gy, fz), u);
        x01 = blend(dot3(hash3(xi, yi, zj), fx, fy, gz), dot3(hash3(xj, yi, zj), gx, fy, gz), u);
        x11 = blend(dot3(hash3(xi, yj, zj), fx, gy, gz), dot3(hash3(xj, yj, zj), gx, gy, gz), u);
        r = blend(blend(x00, x10, v), blend(x01, x11, v), w);
      end else begin
        x0 = blend(dot2(hash2(xi, yi), fx, fy), dot2(hash2(xj, yi), gx, fy), u);
        x1 = blend(dot2(hash2(xi, yj), fx, gy), dot2(hash2(xj, yj), gx, gy), u);
        r = blend(x0, x1, v);
      end
      if (OutFracBits >= FracBits) r = r <<< (OutFracBits - FracBits);
      else r = fshift(r, FracBits - OutFracBits);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[OutW-1:0];
    endfunction

    function void note_point(logic three, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      pending.push_back(noise(three, cx, cy, cz));
    endfunction

    function void check_noise(logic signed [OutW-1:0] got);
      logic signed [OutW-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected noise_value %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: noise_value expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic signed [CoordW-1:0] x_coord_i = '0;
  logic signed [CoordW-1:0] y_coord_i = '0;
  logic signed [CoordW-1:0] z_coord_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OutW-1:0] noise_value_o;
  logic feeding_done = 1'b0;

  noise_scoreboard sb = new();

  gradient_noise_2d_3d_core dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_point(logic three, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= three;
    x_coord_i <= cx;
    y_coord_i <= cy;
    z_coord_i <= cz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_point(three, cx, cy, cz);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 3))
      0: c[31:FracBits] = (CoordW - FracBits)'($urandom_range(0, 7) - 4);
      1: c[FracBits-1:0] = '0;
      default: ;
    endcase
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_noise(noise_value_o);
  end

  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (!feeding_done && $urandom_range(0, 9) < 3) begin
        g = gap_len() + 1;
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    logic [31:0] edges[8];
    rst_ni <= 1'b0;
    edges = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
              32'hFFFF0000, 32'h00FF8000, 32'hFFFE0000, 32'h00010000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      send_point(1'b0, edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
      send_point(1'b1, edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    end
    send_point(1'b1, 32'h00FF_FFFF, 32'h00FF_0001, 32'hFF00_0000);
    send_point(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    for (int i = 0; i < NumRandom; i++)
      send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord());
    in_valid_i <= 1'b0;
    feeding_done <= 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

[filelist.f]
src/gnoise_pkg.sv
src/gnoise_fade.sv
src/gradient_noise_2d_3d_core.sv
src/gnoise_checker.sv
sim/gradient_noise_2d_3d_core_tb.sv
